[src/material_text_tokenizer_macros.svh]
// Assertion macros for the material text tokenizer.
// Included by the top level; depends on nothing else.
`ifndef MATERIAL_TEXT_TOKENIZER_MACROS_SVH
`define MATERIAL_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define MTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define MTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mtt_pkg.sv]
// Shared types and constants of the material text tokenizer.
// Used by the front, the bundle queue, the back and the top level.
package mtt_pkg;

    localparam int MAX_SOURCE_BYTES = 65536;
    localparam int COUNT_W          = $clog2(MAX_SOURCE_BYTES + 1);
    localparam int POS_W            = 16;
    localparam logic [POS_W-1:0] SAT16 = {POS_W{1'b1}};

    localparam int MAX_TOKENS = 3;
    localparam int SLOT_W     = $clog2(MAX_TOKENS + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] KIND_END    = 3'd0;
    localparam logic [2:0] KIND_IDENT  = 3'd1;
    localparam logic [2:0] KIND_NUMBER = 3'd2;
    localparam logic [2:0] KIND_SYMBOL = 3'd3;
    localparam logic [2:0] KIND_STRING = 3'd4;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       has_byte;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       token_kind;
        logic [7:0]       symbol_code;
        logic [POS_W-1:0] text_offset;
        logic [POS_W-1:0] text_length;
        logic [POS_W-1:0] token_line;
        logic [POS_W-1:0] token_column;
        logic             last_of_run;
    } t_token;

    // All tokens caused by one input word, oldest in slot 0.
    typedef struct packed {
        logic [SLOT_W-1:0]           count;
        t_token [MAX_TOKENS-1:0]     tokens;
    } t_bundle;

    typedef struct packed {
        logic can_push;
        logic has_data;
    } t_fifo_stat;

endpackage

[src/mtt_front.sv]
// Front of the tokenizer: lexer state and classification of each byte.
// Builds one bundle of tokens per accepted word; depends on mtt_pkg.
module mtt_front import mtt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in_item   i_item,
    input  t_fifo_stat i_stat,
    output logic       o_ready,
    output logic       o_push,
    output t_bundle    o_bundle
);

    typedef enum logic [2:0] {
        MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING,
        MODE_COMMENT, MODE_SLASH, MODE_DOT
    } t_mode;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_E_LOWER    = 8'h65;
    localparam logic [7:0] CH_E_UPPER    = 8'h45;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == SAT16) ? v : v + POS_W'(1);
    endfunction

    function automatic logic is_numeral(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
            || (b == CH_UNDERSCORE);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NEWLINE);
    endfunction

    function automatic t_token make_tok(input logic [2:0] kind, input logic [7:0] sym,
                                        input logic [POS_W-1:0] off,
                                        input logic [POS_W-1:0] len,
                                        input logic [POS_W-1:0] line,
                                        input logic [POS_W-1:0] col);
        t_token t;
        t.token_kind   = kind;
        t.symbol_code  = sym;
        t.text_offset  = off;
        t.text_length  = len;
        t.token_line   = line;
        t.token_column = col;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    t_mode            r_mode, n_mode;
    logic [POS_W-1:0] r_run_start, n_run_start;
    logic [POS_W-1:0] r_run_line, n_run_line;
    logic [POS_W-1:0] r_run_column, n_run_column;
    logic [POS_W-1:0] r_run_length, n_run_length;
    logic [POS_W-1:0] r_cur_offset, n_cur_offset;
    logic [POS_W-1:0] r_cur_line, n_cur_line;
    logic [POS_W-1:0] r_cur_column, n_cur_column;
    logic [7:0]       r_prior, n_prior;
    logic [COUNT_W-1:0] r_byte_count, n_byte_count;

    logic [POS_W-1:0] adv_offset, adv_line, adv_column;
    t_bundle          n_bundle;
    logic             accept;

    assign o_ready = i_stat.can_push;
    assign accept  = i_valid && o_ready;

    // Cursor position after the current byte; a byte moves it at most once.
    assign adv_offset = sat_inc(r_cur_offset);
    assign adv_line   = (i_item.source_byte == CH_NEWLINE) ? sat_inc(r_cur_line) : r_cur_line;
    assign adv_column = (i_item.source_byte == CH_NEWLINE) ? POS_W'(1) : sat_inc(r_cur_column);

    always_comb begin
        logic [7:0]        b;
        logic              idle_go;
        logic              do_adv;
        logic [SLOT_W-1:0] cnt;
        b            = i_item.source_byte;
        idle_go      = 1'b0;
        do_adv       = 1'b0;
        cnt          = '0;
        n_bundle     = '0;
        n_mode       = r_mode;
        n_run_start  = r_run_start;
        n_run_line   = r_run_line;
        n_run_column = r_run_column;
        n_run_length = r_run_length;
        n_cur_offset = r_cur_offset;
        n_cur_line   = r_cur_line;
        n_cur_column = r_cur_column;
        n_prior      = r_prior;
        n_byte_count = r_byte_count;

        if (i_item.has_byte && (r_byte_count < COUNT_W'(MAX_SOURCE_BYTES))) begin
            n_byte_count = r_byte_count + COUNT_W'(1);
            idle_go      = 1'b1;
            case (r_mode)
                MODE_IDENT: begin
                    if (is_ident_start(b) || is_numeral(b)) begin
                        n_run_length = sat_inc(r_run_length);
                        do_adv       = 1'b1;
                        idle_go      = 1'b0;
                    end else begin
                        n_bundle.tokens[cnt] = make_tok(KIND_IDENT, 8'd0, r_run_start,
                            r_run_length, r_run_line, r_run_column);
                        cnt = cnt + SLOT_W'(1);
                    end
                end
                MODE_NUMBER: begin
                    if (is_numeral(b) || (b == CH_DOT) || (b == CH_E_LOWER)
                        || (b == CH_E_UPPER)
                        || (((b == CH_MINUS) || (b == CH_PLUS))
                            && ((r_prior == CH_E_LOWER) || (r_prior == CH_E_UPPER)))) begin
                        n_run_length = sat_inc(r_run_length);
                        n_prior      = b;
                        do_adv       = 1'b1;
                        idle_go      = 1'b0;
                    end else begin
                        n_bundle.tokens[cnt] = make_tok(KIND_NUMBER, 8'd0, r_run_start,
                            r_run_length, r_run_line, r_run_column);
                        cnt = cnt + SLOT_W'(1);
                    end
                end
                MODE_STRING: begin
                    if (b == CH_QUOTE) begin
                        n_bundle.tokens[cnt] = make_tok(KIND_STRING, 8'd0, r_run_start,
                            r_run_length, r_run_line, r_run_column);
                        cnt    = cnt + SLOT_W'(1);
                        n_mode = MODE_IDLE;
                    end else begin
                        n_run_length = sat_inc(r_run_length);
                    end
                    do_adv  = 1'b1;
                    idle_go = 1'b0;
                end
                MODE_COMMENT: begin
                    if (b != CH_NEWLINE) begin
                        do_adv  = 1'b1;
                        idle_go = 1'b0;
                    end
                end
                MODE_SLASH: begin
                    if (b == CH_SLASH) begin
                        n_mode  = MODE_COMMENT;
                        do_adv  = 1'b1;
                        idle_go = 1'b0;
                    end else begin
                        n_bundle.tokens[cnt] = make_tok(KIND_SYMBOL, CH_SLASH, r_run_start,
                            r_run_length, r_run_line, r_run_column);
                        cnt = cnt + SLOT_W'(1);
                    end
                end
                MODE_DOT: begin
                    if (is_numeral(b)) begin
                        n_mode       = MODE_NUMBER;
                        n_run_length = POS_W'(2);
                        n_prior      = b;
                        do_adv       = 1'b1;
                        idle_go      = 1'b0;
                    end else begin
                        n_bundle.tokens[cnt] = make_tok(KIND_SYMBOL, CH_DOT, r_run_start,
                            r_run_length, r_run_line, r_run_column);
                        cnt = cnt + SLOT_W'(1);
                    end
                end
                default: begin
                end
            endcase

            // Byte that starts afresh from the idle state.
            if (idle_go) begin
                n_mode = MODE_IDLE;
                do_adv = 1'b1;
                if (!is_blank(b)) begin
                    n_run_start  = r_cur_offset;
                    n_run_line   = r_cur_line;
                    n_run_column = r_cur_column;
                    n_run_length = POS_W'(1);
                    if (is_ident_start(b)) begin
                        n_mode = MODE_IDENT;
                    end else if (is_numeral(b)) begin
                        n_mode  = MODE_NUMBER;
                        n_prior = b;
                    end else if (b == CH_DOT) begin
                        n_mode = MODE_DOT;
                    end else if (b == CH_SLASH) begin
                        n_mode = MODE_SLASH;
                    end else if (b == CH_QUOTE) begin
                        n_mode       = MODE_STRING;
                        n_run_length = '0;
                        n_run_start  = adv_offset;
                    end else begin
                        n_bundle.tokens[cnt] = make_tok(KIND_SYMBOL, b, r_cur_offset,
                            POS_W'(1), r_cur_line, r_cur_column);
                        cnt = cnt + SLOT_W'(1);
                    end
                end
            end

            if (do_adv) begin
                n_cur_offset = adv_offset;
                n_cur_line   = adv_line;
                n_cur_column = adv_column;
            end
        end

        if (i_item.end_of_source) begin
            case (n_mode)
                MODE_IDENT: begin
                    n_bundle.tokens[cnt] = make_tok(KIND_IDENT, 8'd0, n_run_start,
                        n_run_length, n_run_line, n_run_column);
                    cnt = cnt + SLOT_W'(1);
                end
                MODE_NUMBER: begin
                    n_bundle.tokens[cnt] = make_tok(KIND_NUMBER, 8'd0, n_run_start,
                        n_run_length, n_run_line, n_run_column);
                    cnt = cnt + SLOT_W'(1);
                end
                MODE_STRING: begin
                    n_bundle.tokens[cnt] = make_tok(KIND_STRING, 8'd0, n_run_start,
                        n_run_length, n_run_line, n_run_column);
                    cnt = cnt + SLOT_W'(1);
                end
                MODE_SLASH: begin
                    n_bundle.tokens[cnt] = make_tok(KIND_SYMBOL, CH_SLASH, n_run_start,
                        n_run_length, n_run_line, n_run_column);
                    cnt = cnt + SLOT_W'(1);
                end
                MODE_DOT: begin
                    n_bundle.tokens[cnt] = make_tok(KIND_SYMBOL, CH_DOT, n_run_start,
                        n_run_length, n_run_line, n_run_column);
                    cnt = cnt + SLOT_W'(1);
                end
                default: begin
                end
            endcase
            n_bundle.tokens[cnt] = make_tok(KIND_END, 8'd0, n_cur_offset, '0,
                n_cur_line, n_cur_column);
            cnt = cnt + SLOT_W'(1);

            n_mode       = MODE_IDLE;
            n_run_start  = '0;
            n_run_line   = POS_W'(1);
            n_run_column = POS_W'(1);
            n_run_length = '0;
            n_cur_offset = '0;
            n_cur_line   = POS_W'(1);
            n_cur_column = POS_W'(1);
            n_prior      = '0;
            n_byte_count = '0;
        end

        if (cnt != '0) begin
            n_bundle.tokens[cnt - SLOT_W'(1)].last_of_run = 1'b1;
        end
        n_bundle.count = cnt;
    end

    assign o_bundle = n_bundle;
    assign o_push   = accept && (n_bundle.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_run_start  <= '0;
            r_run_line   <= POS_W'(1);
            r_run_column <= POS_W'(1);
            r_run_length <= '0;
            r_cur_offset <= '0;
            r_cur_line   <= POS_W'(1);
            r_cur_column <= POS_W'(1);
            r_prior      <= '0;
            r_byte_count <= '0;
        end else if (accept) begin
            r_mode       <= n_mode;
            r_run_start  <= n_run_start;
            r_run_line   <= n_run_line;
            r_run_column <= n_run_column;
            r_run_length <= n_run_length;
            r_cur_offset <= n_cur_offset;
            r_cur_line   <= n_cur_line;
            r_cur_column <= n_cur_column;
            r_prior      <= n_prior;
            r_byte_count <= n_byte_count;
        end
    end

endmodule

[src/mtt_fifo.sv]
// Short queue of token bundles between the front and the back.
// Depends on mtt_pkg for the bundle type and the depth.
module mtt_fifo import mtt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_bundle    i_bundle,
    input  logic       i_pop,
    output t_fifo_stat o_stat,
    output t_bundle    o_head
);

    t_bundle               r_store [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
    endfunction

    assign o_stat.can_push = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_stat.has_data = (r_count != '0);
    assign o_head          = r_store[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

[src/mtt_back.sv]
// Back of the tokenizer: unpacks bundles into single tokens.
// Drives the registered output channel; depends on mtt_pkg.
module mtt_back import mtt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_stat i_stat,
    input  t_bundle    i_head,
    input  logic       i_ready,
    output logic       o_pop,
    output logic       o_valid,
    output t_token     o_token
);

    logic              r_valid;
    t_token            r_token;
    logic [SLOT_W-1:0] r_slot;
    logic              load;

    assign load  = (!r_valid || i_ready) && i_stat.has_data;
    assign o_pop = load && (r_slot == i_head.count - SLOT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_slot  <= o_pop ? '0 : r_slot + SLOT_W'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token <= i_head.tokens[r_slot];
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;

endmodule

[src/material_text_tokenizer.sv]
// Top level of the material text tokenizer: front, bundle queue and back.
// Depends on mtt_pkg, mtt_front, mtt_fifo, mtt_back and the assertion macros.
//
//   Channel   Direction  Handshake            Word
//   input     in         i_valid / o_ready    t_in_item (one source byte)
//   output    out        o_valid / i_ready    t_token   (one token)
//
// The front takes one source byte a cycle whenever the bundle queue has a free
// entry; all tokens a byte causes (up to three) land in that queue in the same
// cycle as one bundle. The back hands out one token a cycle from a register
// while the output is ready and the queue holds data; bytes that yield no token
// push no bundle. Reset is synchronous; there is no clearing pass. A stall on
// the output fills the four-entry queue before the input stalls.
`include "material_text_tokenizer_macros.svh"

module material_text_tokenizer import mtt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    output t_token   o_token
);

    t_fifo_stat w_stat;
    t_bundle    w_push_bundle;
    t_bundle    w_head;
    logic       w_push;
    logic       w_pop;

    // Conditions watched by the assertions below.
    logic       w_out_end;
    logic       w_out_sym;
    logic       w_no_sym;
    logic       w_no_text;
    logic       w_in_end;

    // Lexer state and token building; a word is taken only when the queue has room.
    mtt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_stat   (w_stat),
        .o_ready  (o_ready),
        .o_push   (w_push),
        .o_bundle (w_push_bundle)
    );

    // Bundles wait here, so bursts of tokens do not stall the byte stream at once.
    mtt_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_push_bundle),
        .i_pop    (w_pop),
        .o_stat   (w_stat),
        .o_head   (w_head)
    );

    // The back walks through each bundle one token at a time.
    mtt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (w_stat),
        .i_head   (w_head),
        .i_ready  (i_ready),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_token  (o_token)
    );

    assign w_out_end = o_valid && (o_token.token_kind == KIND_END);
    assign w_out_sym = (o_token.token_kind == KIND_SYMBOL);
    assign w_no_sym  = (o_token.symbol_code == '0);
    assign w_no_text = (o_token.text_length == '0);
    assign w_in_end  = i_valid && o_ready && i_item.end_of_source;

    // The end token always closes the run of tokens of its word.
    `MTT_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, w_out_end, o_token.last_of_run, "end not last")

    // An end token carries no text and no symbol.
    `MTT_ASSERT_NOW(a_end_empty, i_clk, i_rst_n, w_out_end, w_no_text && w_no_sym, "end with text")

    // Only symbol tokens carry a symbol code.
    `MTT_ASSERT_NOW(a_sym_only, i_clk, i_rst_n, o_valid && !w_out_sym, w_no_sym, "stray symbol")

    // A word that ends the source always pushes a bundle into the queue.
    `MTT_ASSERT_NOW(a_end_pushes, i_clk, i_rst_n, w_in_end, w_push, "end pushed nothing")

endmodule
